// ===== design/gnp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnp_pkg
// Shared types, constants and helpers for the 2-D Neville grid interpolator.
// ----------------------------------------------------------------------------
package gnp_pkg;

    // Grid store geometry
    localparam int MAX_POINTS  = 64;
    localparam int IDX_W       = $clog2(MAX_POINTS);
    localparam int MAX_ORDER   = 7;
    localparam int ORD_W       = $clog2(MAX_ORDER + 1);
    localparam int NUM_TABLES  = 6;
    localparam int TBL_W       = 3;
    localparam int STORE_DEPTH = NUM_TABLES * MAX_POINTS * MAX_POINTS;
    localparam int ADDR_W      = TBL_W + 2 * IDX_W;
    localparam int ENTRY_W     = 64;

    // Configuration port
    localparam int REG_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;
    localparam logic [REG_IDX_W-1:0] REG_POLY_ORDER  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DERIV_AVAIL = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_U_ORIGIN    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_V_ORIGIN    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_U_INV_STEP  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_V_INV_STEP  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_U_INTERVALS = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_V_INTERVALS = 3'd7;

    // Item kinds
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Table codes
    localparam logic [TBL_W-1:0] TBL_VALUE = 3'd0;
    localparam logic [TBL_W-1:0] TBL_DU    = 3'd1;
    localparam logic [TBL_W-1:0] TBL_DV    = 3'd2;
    localparam logic [TBL_W-1:0] TBL_DUU   = 3'd3;
    localparam logic [TBL_W-1:0] TBL_DVV   = 3'd4;
    localparam logic [TBL_W-1:0] TBL_DUV   = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_DERIV = 2'd1;
    localparam logic [1:0] ST_U_RANGE  = 2'd2;

    typedef struct packed {
        logic [ORD_W-1:0]  poly_order;
        logic [1:0]        deriv_avail;
        logic signed [31:0] u_origin;
        logic signed [31:0] v_origin;
        logic [31:0]       u_inv_step;
        logic [31:0]       v_inv_step;
        logic [IDX_W-1:0]  u_intervals;
        logic [IDX_W-1:0]  v_intervals;
    } cfg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_GRID_U,
        S_GRID_V,
        S_GRID_CHK,
        S_WIN_S,
        S_WIN_X,
        S_ROW_RD,
        S_ROW_WR,
        S_NV_START,
        S_NV_F,
        S_NV_FSAT,
        S_NV_DRE,
        S_NV_URE,
        S_NV_UIM,
        S_ROW_DONE,
        S_FIN_LOAD,
        S_FINISH
    } state_t;

    // Rounded reciprocal of a node distance, Q16.16
    function automatic logic [16:0] recip(input logic [ORD_W-1:0] k);
        logic [16:0] r;
        case (k)
            3'd1:    r = 17'd65536;
            3'd2:    r = 17'd32768;
            3'd3:    r = 17'd21845;
            3'd4:    r = 17'd16384;
            3'd5:    r = 17'd13107;
            3'd6:    r = 17'd10923;
            3'd7:    r = 17'd9362;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // Saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ===== design/gnp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gnp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/gnp_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnp_regs
// APB configuration register bank; always ready, zero wait states.
// ----------------------------------------------------------------------------
module gnp_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gnp_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output gnp_pkg::cfg_t                 cfg
);

    gnp_pkg::cfg_t                cfg_reg;
    logic                         wr_en;
    logic [gnp_pkg::REG_IDX_W-1:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[gnp_pkg::REG_ADDR_W-1:2];

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poly_order  <= 3'd3;
            cfg_reg.deriv_avail <= 2'd0;
            cfg_reg.u_origin    <= 32'sd0;
            cfg_reg.v_origin    <= 32'sd0;
            cfg_reg.u_inv_step  <= 32'd65536;
            cfg_reg.v_inv_step  <= 32'd65536;
            cfg_reg.u_intervals <= 6'd63;
            cfg_reg.v_intervals <= 6'd63;
        end
        else if (wr_en)
        begin
            case (idx)
                gnp_pkg::REG_POLY_ORDER:  cfg_reg.poly_order  <= pwdata[gnp_pkg::ORD_W-1:0];
                gnp_pkg::REG_DERIV_AVAIL: cfg_reg.deriv_avail <= pwdata[1:0];
                gnp_pkg::REG_U_ORIGIN:    cfg_reg.u_origin    <= pwdata;
                gnp_pkg::REG_V_ORIGIN:    cfg_reg.v_origin    <= pwdata;
                gnp_pkg::REG_U_INV_STEP:  cfg_reg.u_inv_step  <= pwdata;
                gnp_pkg::REG_V_INV_STEP:  cfg_reg.v_inv_step  <= pwdata;
                gnp_pkg::REG_U_INTERVALS: cfg_reg.u_intervals <= pwdata[gnp_pkg::IDX_W-1:0];
                gnp_pkg::REG_V_INTERVALS: cfg_reg.v_intervals <= pwdata[gnp_pkg::IDX_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (idx)
            gnp_pkg::REG_POLY_ORDER:  prdata = 32'(cfg_reg.poly_order);
            gnp_pkg::REG_DERIV_AVAIL: prdata = 32'(cfg_reg.deriv_avail);
            gnp_pkg::REG_U_ORIGIN:    prdata = cfg_reg.u_origin;
            gnp_pkg::REG_V_ORIGIN:    prdata = cfg_reg.v_origin;
            gnp_pkg::REG_U_INV_STEP:  prdata = cfg_reg.u_inv_step;
            gnp_pkg::REG_V_INV_STEP:  prdata = cfg_reg.v_inv_step;
            gnp_pkg::REG_U_INTERVALS: prdata = 32'(cfg_reg.u_intervals);
            gnp_pkg::REG_V_INTERVALS: prdata = 32'(cfg_reg.v_intervals);
            default:                  prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/grid_neville_interp_2d.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_neville_interp_2d
// Two-dimensional Neville interpolator over six complex Q16.16 grid tables.
//
// Input stream (s_axis_*): tuser carries the kind (write or query) and the
// table select; tdata carries write indices/entry and query point/orders.
// A write transaction stores one table entry; writes to table codes 6 and 7
// are dropped. A query returns one result transaction on m_axis_* with
// real/imag in tdata, status in tuser. APB registers set polynomial order,
// derivative availability and the grid. A query with order n runs a window
// set-up, then (n+1) row passes of (n+1) store reads plus one Neville pass,
// then one final Neville pass. Each Neville step uses the one shared 33x33
// multiplier for the f, real and imaginary products. Error queries skip the
// window set-up and all passes. s_axis_tready is high only between
// queries; writes flow one per cycle while no query is in progress.
// The result waits in an output register while m_axis_tready is low; the
// next query may start meanwhile but cannot finish until it drains.
// Reset clears control state and sets configuration registers to defaults;
// the store is undefined until written and needs no clearing pass.
// ----------------------------------------------------------------------------
module grid_neville_interp_2d (
    input  logic                           clk,
    input  logic                           rst_n,
    // tdata: u_index, v_index, entry_real, entry_imag, u_coord, v_coord,
    //        u_deriv, v_deriv
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [143:0]                   s_axis_tdata,
    // tuser: op, table_sel
    input  logic [3:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata: result_real, result_imag
    output logic [63:0]                    m_axis_tdata,
    // tuser: status
    output logic [1:0]                     m_axis_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gnp_pkg::REG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    localparam int IW = gnp_pkg::IDX_W;
    localparam int OW = gnp_pkg::ORD_W;

    gnp_pkg::cfg_t  cfg;
    gnp_pkg::state_t state_reg, state_next;

    // Input fields
    logic                    in_op;
    logic [gnp_pkg::TBL_W-1:0] in_tsel;
    logic [IW-1:0]           in_u_index, in_v_index;
    logic signed [31:0]      in_entry_real, in_entry_imag, in_u_coord, in_v_coord;
    logic [1:0]              in_u_deriv, in_v_deriv;
    logic                    s_acc;

    assign in_op         = s_axis_tuser[0];
    assign in_tsel       = s_axis_tuser[3:1];
    assign in_u_index    = s_axis_tdata[5:0];
    assign in_v_index    = s_axis_tdata[11:6];
    assign in_entry_real = s_axis_tdata[43:12];
    assign in_entry_imag = s_axis_tdata[75:44];
    assign in_u_coord    = s_axis_tdata[107:76];
    assign in_v_coord    = s_axis_tdata[139:108];
    assign in_u_deriv    = s_axis_tdata[141:140];
    assign in_v_deriv    = s_axis_tdata[143:142];
    assign s_acc         = s_axis_tvalid && s_axis_tready;

    // Query registers
    logic signed [32:0]       du_reg, dv_reg;
    logic [gnp_pkg::TBL_W-1:0] tbl_reg;
    logic signed [49:0]       tu_reg, tv_reg;
    logic [IW-1:0]            su_reg, sv_reg;
    logic signed [31:0]       xu_reg, x_reg;
    logic [OW-1:0]            ord_reg;
    logic [OW-1:0]            row_reg, k_reg, i_reg, j_reg;
    logic                     final_reg;

    // Neville working set
    logic signed [31:0] sp_re_reg [0:gnp_pkg::MAX_ORDER];
    logic signed [31:0] sp_im_reg [0:gnp_pkg::MAX_ORDER];
    logic signed [31:0] col_re_reg [0:gnp_pkg::MAX_ORDER];
    logic signed [31:0] col_im_reg [0:gnp_pkg::MAX_ORDER];
    logic signed [31:0] c_re_reg, c_im_reg, f_reg;

    // Shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod_reg;
    logic signed [49:0] prod_sh;

    // Result and output registers
    logic signed [31:0] res_re_reg, res_im_reg;
    logic [1:0]         res_st_reg;
    logic signed [31:0] out_re_reg, out_im_reg;
    logic [1:0]         out_st_reg;
    logic               m_valid_reg;

    // Store ports
    logic                       ram_we;
    logic [gnp_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [gnp_pkg::ENTRY_W-1:0] ram_rdata;

    // Misc combinational
    logic               need1, need2, deriv_bad;
    logic [gnp_pkg::TBL_W-1:0] tbl_sel;
    logic [OW-1:0]      sp_idx;
    logic signed [31:0] sp_re_rd, sp_im_rd;
    logic signed [31:0] upd_val;
    logic               u_bad;
    logic               out_free;

    gnp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gnp_ram #(
        .WIDTH (gnp_pkg::ENTRY_W),
        .DEPTH (gnp_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({in_entry_imag, in_entry_real}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Q16.16 grid position from magnitude product and sign
    function automatic logic signed [49:0] to_grid(input logic [63:0] p, input logic neg);
        logic [63:0] pr;
        logic signed [49:0] r;
        pr = p + 64'd65535;
        if (neg)
            r = -$signed({2'b00, pr[63:16]});
        else
            r = $signed({2'b00, p[63:16]});
        return r;
    endfunction

    // Centred window start, clamped to the grid
    function automatic logic [IW-1:0] win_start(input logic signed [49:0] t,
                                                input logic [OW-1:0] ord,
                                                input logic [IW-1:0] nint);
        logic signed [34:0] s;
        logic signed [8:0]  lim;
        logic [IW-1:0]      r;
        s   = 35'(t >>> 16) - 35'($signed({1'b0, ord >> 1}));
        lim = $signed({3'b000, nint}) - $signed({6'b000000, ord});
        if (s < 0)
            r = '0;
        else if (s > 35'(lim))
            r = (lim < 0) ? '0 : lim[IW-1:0];
        else
            r = s[IW-1:0];
        return r;
    endfunction

    // Derivative availability and table choice
    always_comb
    begin
        need2 = (in_u_deriv == 2'd2) || (in_v_deriv == 2'd2) ||
                ((in_u_deriv == 2'd1) && (in_v_deriv == 2'd1));
        need1 = (in_u_deriv == 2'd1) || (in_v_deriv == 2'd1);
        deriv_bad = (need2 && !cfg.deriv_avail[1]) || (need1 && !cfg.deriv_avail[0]) ||
                    (in_u_deriv == 2'd3) || (in_v_deriv == 2'd3);
        if (in_u_deriv == 2'd0 && in_v_deriv == 2'd0)
            tbl_sel = gnp_pkg::TBL_VALUE;
        else if (in_u_deriv == 2'd1 && in_v_deriv == 2'd0)
            tbl_sel = gnp_pkg::TBL_DU;
        else if (in_u_deriv == 2'd0 && in_v_deriv == 2'd1)
            tbl_sel = gnp_pkg::TBL_DV;
        else if (in_u_deriv == 2'd2 && in_v_deriv == 2'd0)
            tbl_sel = gnp_pkg::TBL_DUU;
        else if (in_u_deriv == 2'd0 && in_v_deriv == 2'd2)
            tbl_sel = gnp_pkg::TBL_DVV;
        else
            tbl_sel = gnp_pkg::TBL_DUV;
    end

    assign sp_idx   = (state_reg == gnp_pkg::S_NV_START) ? i_reg : j_reg;
    assign sp_re_rd = sp_re_reg[sp_idx];
    assign sp_im_rd = sp_im_reg[sp_idx];
    assign prod_sh  = $signed(prod_reg[65:16]);
    assign u_bad    = (tu_reg < 0) || (tu_reg > $signed({28'd0, cfg.u_intervals, 16'd0}));
    assign out_free = !m_valid_reg || m_axis_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gnp_pkg::S_IDLE:
            begin
                if (s_acc && in_op == gnp_pkg::OP_QUERY)
                    state_next = deriv_bad ? gnp_pkg::S_FINISH : gnp_pkg::S_GRID_U;
            end
            gnp_pkg::S_GRID_U:   state_next = gnp_pkg::S_GRID_V;
            gnp_pkg::S_GRID_V:   state_next = gnp_pkg::S_GRID_CHK;
            gnp_pkg::S_GRID_CHK: state_next = u_bad ? gnp_pkg::S_FINISH : gnp_pkg::S_WIN_S;
            gnp_pkg::S_WIN_S:    state_next = gnp_pkg::S_WIN_X;
            gnp_pkg::S_WIN_X:    state_next = gnp_pkg::S_ROW_RD;
            gnp_pkg::S_ROW_RD:   state_next = gnp_pkg::S_ROW_WR;
            gnp_pkg::S_ROW_WR:
            begin
                if (k_reg != ord_reg)
                    state_next = gnp_pkg::S_ROW_RD;
                else if (ord_reg == '0)
                    state_next = gnp_pkg::S_ROW_DONE;
                else
                    state_next = gnp_pkg::S_NV_START;
            end
            gnp_pkg::S_NV_START: state_next = gnp_pkg::S_NV_F;
            gnp_pkg::S_NV_F:     state_next = gnp_pkg::S_NV_FSAT;
            gnp_pkg::S_NV_FSAT:  state_next = gnp_pkg::S_NV_DRE;
            gnp_pkg::S_NV_DRE:   state_next = gnp_pkg::S_NV_URE;
            gnp_pkg::S_NV_URE:   state_next = gnp_pkg::S_NV_UIM;
            gnp_pkg::S_NV_UIM:
            begin
                if (j_reg != '0)
                    state_next = gnp_pkg::S_NV_F;
                else if (i_reg != ord_reg)
                    state_next = gnp_pkg::S_NV_START;
                else
                    state_next = gnp_pkg::S_ROW_DONE;
            end
            gnp_pkg::S_ROW_DONE:
            begin
                if (final_reg)
                    state_next = gnp_pkg::S_FINISH;
                else if (row_reg == ord_reg)
                    state_next = gnp_pkg::S_FIN_LOAD;
                else
                    state_next = gnp_pkg::S_ROW_RD;
            end
            gnp_pkg::S_FIN_LOAD:
                state_next = (ord_reg == '0) ? gnp_pkg::S_ROW_DONE : gnp_pkg::S_NV_START;
            gnp_pkg::S_FINISH:
            begin
                if (out_free)
                    state_next = gnp_pkg::S_IDLE;
            end
            default: state_next = gnp_pkg::S_IDLE;
        endcase
    end

    // Control outputs and multiplier operand select
    always_comb
    begin
        s_axis_tready = (state_reg == gnp_pkg::S_IDLE);
        ram_we    = s_acc && (in_op == gnp_pkg::OP_WRITE) &&
                    (in_tsel < gnp_pkg::TBL_W'(gnp_pkg::NUM_TABLES));
        ram_waddr = {in_tsel, in_u_index, in_v_index};
        ram_raddr = {tbl_reg, IW'(su_reg + IW'(row_reg)), IW'(sv_reg + IW'(k_reg))};
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            gnp_pkg::S_GRID_U:
            begin
                mul_a = du_reg[32] ? -du_reg : du_reg;
                mul_b = $signed({1'b0, cfg.u_inv_step});
            end
            gnp_pkg::S_GRID_V:
            begin
                mul_a = dv_reg[32] ? -dv_reg : dv_reg;
                mul_b = $signed({1'b0, cfg.v_inv_step});
            end
            gnp_pkg::S_NV_F:
            begin
                mul_a = 33'(x_reg) - $signed({1'b0, i_reg, 16'd0});
                mul_b = $signed({16'd0, gnp_pkg::recip(OW'(i_reg - j_reg))});
            end
            gnp_pkg::S_NV_DRE:
            begin
                mul_a = 33'(c_re_reg) - 33'(sp_re_rd);
                mul_b = 33'(f_reg);
            end
            gnp_pkg::S_NV_URE:
            begin
                mul_a = 33'(c_im_reg) - 33'(sp_im_rd);
                mul_b = 33'(f_reg);
            end
            default: ;
        endcase
    end

    // Shared Neville update: saturated c + diff*f
    always_comb
    begin
        if (state_reg == gnp_pkg::S_NV_URE)
            upd_val = gnp_pkg::sat32(64'(c_re_reg) + 64'(prod_sh));
        else
            upd_val = gnp_pkg::sat32(64'(c_im_reg) + 64'(prod_sh));
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= gnp_pkg::S_IDLE;
            m_valid_reg <= 1'b0;
            row_reg     <= '0;
            k_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            final_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == gnp_pkg::S_FINISH && out_free)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                gnp_pkg::S_WIN_X:
                begin
                    row_reg   <= '0;
                    k_reg     <= '0;
                    final_reg <= 1'b0;
                end
                gnp_pkg::S_ROW_WR:
                begin
                    if (k_reg != ord_reg)
                        k_reg <= k_reg + 1'b1;
                    i_reg <= OW'(1);
                end
                gnp_pkg::S_NV_START:
                    j_reg <= i_reg - 1'b1;
                gnp_pkg::S_NV_UIM:
                begin
                    if (j_reg != '0)
                        j_reg <= j_reg - 1'b1;
                    else if (i_reg != ord_reg)
                        i_reg <= i_reg + 1'b1;
                end
                gnp_pkg::S_ROW_DONE:
                begin
                    row_reg <= row_reg + 1'b1;
                    k_reg   <= '0;
                end
                gnp_pkg::S_FIN_LOAD:
                begin
                    final_reg <= 1'b1;
                    i_reg     <= OW'(1);
                end
                default: ;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            gnp_pkg::S_IDLE:
            begin
                du_reg   <= 33'(in_u_coord) - 33'(cfg.u_origin);
                dv_reg   <= 33'(in_v_coord) - 33'(cfg.v_origin);
                tbl_reg  <= tbl_sel;
                ord_reg  <= cfg.poly_order;
                res_re_reg <= 32'sd0;
                res_im_reg <= 32'sd0;
                res_st_reg <= deriv_bad ? gnp_pkg::ST_NO_DERIV : gnp_pkg::ST_OK;
            end
            gnp_pkg::S_GRID_V:
                tu_reg <= to_grid(prod_reg[63:0], du_reg[32]);
            gnp_pkg::S_GRID_CHK:
            begin
                tv_reg <= to_grid(prod_reg[63:0], dv_reg[32]);
                if (u_bad)
                    res_st_reg <= gnp_pkg::ST_U_RANGE;
            end
            gnp_pkg::S_WIN_S:
            begin
                su_reg <= win_start(tu_reg, ord_reg, cfg.u_intervals);
                sv_reg <= win_start(tv_reg, ord_reg, cfg.v_intervals);
            end
            gnp_pkg::S_WIN_X:
            begin
                xu_reg <= gnp_pkg::sat32(64'(tu_reg) - 64'($signed({1'b0, su_reg, 16'd0})));
                x_reg  <= gnp_pkg::sat32(64'(tv_reg) - 64'($signed({1'b0, sv_reg, 16'd0})));
            end
            gnp_pkg::S_ROW_WR:
            begin
                sp_re_reg[k_reg] <= ram_rdata[31:0];
                sp_im_reg[k_reg] <= ram_rdata[63:32];
            end
            gnp_pkg::S_NV_START:
            begin
                c_re_reg <= sp_re_rd;
                c_im_reg <= sp_im_rd;
            end
            gnp_pkg::S_NV_FSAT:
                f_reg <= gnp_pkg::sat32(64'(prod_sh));
            gnp_pkg::S_NV_URE:
            begin
                sp_re_reg[j_reg] <= upd_val;
                c_re_reg         <= upd_val;
            end
            gnp_pkg::S_NV_UIM:
            begin
                sp_im_reg[j_reg] <= upd_val;
                c_im_reg         <= upd_val;
            end
            gnp_pkg::S_ROW_DONE:
            begin
                if (final_reg)
                begin
                    res_re_reg <= sp_re_reg[0];
                    res_im_reg <= sp_im_reg[0];
                end
                else
                begin
                    col_re_reg[row_reg] <= sp_re_reg[0];
                    col_im_reg[row_reg] <= sp_im_reg[0];
                end
            end
            gnp_pkg::S_FIN_LOAD:
            begin
                for (int n = 0; n <= gnp_pkg::MAX_ORDER; n++)
                begin
                    sp_re_reg[n] <= col_re_reg[n];
                    sp_im_reg[n] <= col_im_reg[n];
                end
                x_reg <= xu_reg;
            end
            gnp_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_re_reg <= res_re_reg;
                    out_im_reg <= res_im_reg;
                    out_st_reg <= res_st_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {out_im_reg, out_re_reg};
    assign m_axis_tuser  = out_st_reg;

endmodule
